>>> hdl/lcm_pkg.sv
// Shared types, constants and the compare function of the color morphology core.
package lcm_pkg;

    localparam int PIX_W       = 24;
    localparam int DIM_W       = 11;
    localparam int MASK_W      = 49;
    localparam int MASK_STRIDE = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 49;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MASK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 3'd4;

    localparam logic MODE_DILATE = 1'b0;
    localparam logic MODE_ERODE  = 1'b1;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        logic   v;
        pixel_t p;
    } cand_t;

    typedef struct packed {
        logic shift_en;
        logic res_en;
        logic mode;
        logic col_ok;
    } cell_ctl_t;

    // keeps the larger (dilate) or smaller (erode) of two candidates
    function automatic cand_t pick(cand_t a, cand_t b, logic mode);
        cand_t r;
        r = a;
        if (b.v) begin
            if (!a.v) begin
                r = b;
            end else if (mode == MODE_ERODE) begin
                if (b.p < a.p) r = b;
            end else begin
                if (b.p > a.p) r = b;
            end
        end
        return r;
    endfunction

endpackage

>>> hdl/lcm_ram.sv
// Generic simple dual port RAM with registered read.
module lcm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (re) rdata <= mem[raddr];
    end

endmodule

>>> hdl/lcm_cell.sv
// One window column cell: holds a pixel column, shifts it on, reduces it under the mask.
module lcm_cell import lcm_pkg::*; #(
    parameter int SIDE = 7
) (
    input  logic                        aclk,
    input  cell_ctl_t                   ctl,
    input  logic [SIDE-1:0]             row_en,
    input  logic [SIDE-1:0][PIX_W-1:0]  col_in,
    output logic [SIDE-1:0][PIX_W-1:0]  col_out,
    output cand_t                       res
);

    logic [SIDE-1:0][PIX_W-1:0] col_reg;
    cand_t                      res_reg;
    cand_t                      res_next;

    always_comb begin
        res_next = '0;
        for (int a = 0; a < SIDE; a++) begin
            if (row_en[a] && ctl.col_ok) begin
                res_next = pick(res_next, cand_t'{v: 1'b1, p: col_reg[a]}, ctl.mode);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.shift_en) col_reg <= col_in;
        if (ctl.res_en) res_reg <= res_next;
    end

    assign col_out = col_reg;
    assign res     = res_reg;

endmodule

>>> hdl/lexicographic_color_morphology_core.sv
// Stages: line store read, cell row, per column results, output register.
// Throughput: one word per cycle while m_ready holds; after a word that ends an output row
// the s_ side stalls while the row end burst of up to radius+1 results drains.
// The rate is set by the one line store read per column and the shift of the cell row.
// Reset (synchronous, active low) clears position, pipeline valids and config registers;
// the line store is not cleared.
module lexicographic_color_morphology_core import lcm_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 3
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_cmd,
    input  logic [7:0]            s_red,
    input  logic [7:0]            s_green,
    input  logic [7:0]            s_blue,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_red,
    output logic [7:0]            m_out_green,
    output logic [7:0]            m_out_blue,
    output logic                  m_last_of_run,
    output logic                  m_last_of_frame,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int SIDE   = 2 * MAX_RADIUS + 1;
    localparam int ADDR_W = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
    localparam int SLOT_W = $clog2(SIDE);
    localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
    localparam int CW     = DIM_W + 1;

    // configuration
    logic [DIM_W-1:0]  frame_width_reg;
    logic [DIM_W-1:0]  frame_height_reg;
    logic [1:0]        radius_reg;
    logic [MASK_W-1:0] window_mask_reg;
    logic              mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= DIM_W'(64);
            frame_height_reg <= DIM_W'(64);
            radius_reg       <= 2'd1;
            window_mask_reg  <= MASK_W'(115591);
            mode_reg         <= MODE_DILATE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wr_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data[DIM_W-1:0];
                CFG_RADIUS:       radius_reg       <= cfg_wr_data[1:0];
                CFG_WINDOW_MASK:  window_mask_reg  <= cfg_wr_data[MASK_W-1:0];
                CFG_MODE:         mode_reg         <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    logic [CW-1:0]    w_eff, h_eff, r_cw, r2, span;
    logic [RAD_W-1:0] r_eff;

    always_comb begin
        if (frame_width_reg == '0) w_eff = CW'(1);
        else if (int'(frame_width_reg) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
        else w_eff = CW'(frame_width_reg);
        h_eff = (frame_height_reg == '0) ? CW'(1) : CW'(frame_height_reg);
        r_eff = (int'(radius_reg) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius_reg);
        r_cw  = CW'(r_eff);
        r2    = r_cw << 1;
        span  = h_eff + r_cw;
    end

    // position sequencer
    logic [CW-1:0]     col_reg, row_reg, col_next, row_next, col0, row0;
    logic [SLOT_W-1:0] slot_reg, slot_next, slot0;
    logic [RAD_W-1:0]  burst_left_reg;
    logic [CW-1:0]     vcol_reg, vrow_reg;

    function automatic logic [SLOT_W-1:0] inc_slot(logic [SLOT_W-1:0] s);
        return (int'(s) == SIDE - 1) ? '0 : s + SLOT_W'(1);
    endfunction

    always_comb begin
        if (col_reg >= w_eff) begin
            col0  = '0;
            row0  = row_reg + CW'(1);
            slot0 = inc_slot(slot_reg);
        end else begin
            col0  = col_reg;
            row0  = row_reg;
            slot0 = slot_reg;
        end
        if (row0 >= span) begin
            row0  = '0;
            slot0 = '0;
        end
        col_next  = col0 + CW'(1);
        row_next  = row0;
        slot_next = slot0;
        if (col_next >= w_eff) begin
            col_next  = '0;
            row_next  = row0 + CW'(1);
            slot_next = inc_slot(slot0);
        end
        if (row_next >= span) begin
            row_next  = '0;
            slot_next = '0;
        end
    end

    logic ready1, ready2, ready3, ready4;
    logic burst_act, accept, emit_row0, ev_valid;
    logic [CW-1:0] ev_c, ev_row;

    assign burst_act = burst_left_reg != '0;
    assign emit_row0 = row0 >= r_cw;
    assign s_ready   = ready1 && !burst_act;
    assign accept    = s_valid && s_ready;
    assign ev_valid  = burst_act || (s_valid && emit_row0);
    assign ev_c      = burst_act ? vcol_reg : col0;
    assign ev_row    = burst_act ? vrow_reg : row0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            row_reg        <= '0;
            slot_reg       <= '0;
            burst_left_reg <= '0;
            vcol_reg       <= '0;
            vrow_reg       <= '0;
        end else if (accept) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
            // last column of an output row: shift in radius columns past the edge
            if (emit_row0 && col0 == w_eff - CW'(1) && r_eff != '0) begin
                burst_left_reg <= r_eff;
                vcol_reg       <= col0 + CW'(1);
                vrow_reg       <= row0;
            end
        end else if (burst_act && ready1) begin
            burst_left_reg <= burst_left_reg - RAD_W'(1);
            vcol_reg       <= vcol_reg + CW'(1);
        end
    end

    // line store, one RAM per row slot
    pixel_t rd_data [SIDE];

    for (genvar s = 0; s < SIDE; s++) begin : g_line
        lcm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
            .aclk  (aclk),
            .we    (accept && int'(slot0) == s),
            .waddr (col0[ADDR_W-1:0]),
            .wdata ({s_red, s_green, s_blue}),
            .re    (ready1),
            .raddr (col0[ADDR_W-1:0]),
            .rdata (rd_data[s])
        );
    end

    // stage 1: line store read
    logic              v1, emit1, lor1, lof1;
    logic [CW-1:0]     c1, row1;
    logic [SLOT_W-1:0] slot1;
    pixel_t            pix1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1 <= 1'b0;
        end else if (ready1) begin
            v1 <= ev_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1 && ev_valid) begin
            c1    <= ev_c;
            row1  <= ev_row;
            slot1 <= slot0;
            pix1  <= {s_red, s_green, s_blue};
            emit1 <= ev_c >= r_cw;
            lor1  <= (ev_c + CW'(1) < w_eff) || (ev_c == w_eff - CW'(1) + r_cw);
            lof1  <= (ev_row == h_eff - CW'(1) + r_cw) && (ev_c == w_eff - CW'(1) + r_cw);
        end
    end

    // window row a holds the row 2r-a lines back; the newest comes straight from the input
    logic [SIDE-1:0][PIX_W-1:0] col1_data;

    always_comb begin
        int d;
        int sidx;
        for (int a = 0; a < SIDE; a++) begin
            d    = 2 * int'(r_eff) - a;
            sidx = int'(slot1) + SIDE - d;
            if (sidx >= SIDE) sidx = sidx - SIDE;
            if (d == 0) col1_data[a] = pix1;
            else if (d > 0) col1_data[a] = rd_data[sidx[SLOT_W-1:0]];
            else col1_data[a] = '0;
        end
    end

    // stage 2: cell row holds the window columns
    logic          v2, emit2, lor2, lof2;
    logic [CW-1:0] c2, row2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2 <= 1'b0;
        end else if (ready2) begin
            v2 <= v1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready2 && v1) begin
            c2    <= c1;
            row2  <= row1;
            emit2 <= emit1;
            lor2  <= lor1;
            lof2  <= lof1;
        end
    end

    cell_ctl_t                  cell_ctl [SIDE];
    logic [SIDE-1:0]            row_en   [SIDE];
    logic [SIDE-1:0][PIX_W-1:0] chain    [SIDE+1];
    cand_t                      cell_res [SIDE];
    logic [SIDE-1:0]            row_ok;

    always_comb begin
        int                idx;
        logic [MASK_W-1:0] mshift;
        for (int a = 0; a < SIDE; a++) begin
            row_ok[a] = (int'(row2) + a >= int'(r2)) && (int'(row2) + a < int'(h_eff) + int'(r2))
                        && (a <= int'(r2));
        end
        for (int k = 0; k < SIDE; k++) begin
            cell_ctl[k].shift_en = v1 && ready2;
            cell_ctl[k].res_en   = v2 && emit2 && ready3;
            cell_ctl[k].mode     = mode_reg;
            cell_ctl[k].col_ok   = (k <= int'(r2)) && (int'(c2) >= k)
                                   && (int'(c2) - k < int'(w_eff));
            for (int a = 0; a < SIDE; a++) begin
                idx    = a * MASK_STRIDE + int'(r2) - k;
                mshift = window_mask_reg >> idx;
                // the center always counts
                row_en[k][a] = (mshift[0] && row_ok[a])
                               || (a == int'(r_eff) && k == int'(r_eff));
            end
        end
    end

    assign chain[0] = col1_data;

    for (genvar k = 0; k < SIDE; k++) begin : g_cell
        lcm_cell #(.SIDE(SIDE)) u_cell (
            .aclk    (aclk),
            .ctl     (cell_ctl[k]),
            .row_en  (row_en[k]),
            .col_in  (chain[k]),
            .col_out (chain[k+1]),
            .res     (cell_res[k])
        );
    end

    // stage 3: per column results
    logic v3, lor3, lof3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3 <= 1'b0;
        end else if (ready3) begin
            v3 <= v2 && emit2;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready3 && v2 && emit2) begin
            lor3 <= lor2;
            lof3 <= lof2;
        end
    end

    cand_t best;

    always_comb begin
        best = '0;
        for (int k = 0; k < SIDE; k++) begin
            best = pick(best, cell_res[k], mode_reg);
        end
    end

    // stage 4: output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (ready4) begin
            m_valid <= v3;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready4 && v3) begin
            m_out_red       <= best.p[23:16];
            m_out_green     <= best.p[15:8];
            m_out_blue      <= best.p[7:0];
            m_last_of_run   <= lor3;
            m_last_of_frame <= lof3;
        end
    end

    assign ready4 = !m_valid || m_ready;
    assign ready3 = !v3 || ready4;
    assign ready2 = !v2 || !emit2 || ready3;
    assign ready1 = !v1 || ready2;

endmodule

>>> hdl/lcm_checker.sv
// Port level checks of the color morphology core, bound to the top level.
module lcm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_red,
    input logic [7:0] m_out_green,
    input logic [7:0] m_out_blue,
    input logic       m_last_of_run,
    input logic       m_last_of_frame
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable({m_out_red, m_out_green, m_out_blue,
                                                    m_last_of_run, m_last_of_frame}))
        else $error("result word changed while stalled");

    // bottom right pixel closes the row end burst
    a_frame_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_of_frame |-> m_last_of_run)
        else $error("frame end without run end");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word after reset");

endmodule

bind lexicographic_color_morphology_core lcm_checker u_lcm_checker (.*);

>>> test/tb_top.sv
// Self-checking testbench for the lexicographic color morphology core.
module tb_top;
    import lcm_pkg::*;

    localparam int SLOT_N     = 7;
    localparam int MAXW       = 1024;
    localparam int WDOG_LIMIT = 5000;
    localparam int HOLD_LEN   = 200;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_run;
        logic       last_frame;
    } morph_pix_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       typed;
        logic [7:0] e_red;
        logic [7:0] e_green;
        logic [7:0] e_blue;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_cmd = 1'b0;
    logic [7:0]            s_red = '0, s_green = '0, s_blue = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [7:0]            m_out_red, m_out_green, m_out_blue;
    logic                  m_last_of_run, m_last_of_frame;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    always #1 aclk = ~aclk;

    lexicographic_color_morphology_core i_dut (.*);

    // predictor state
    pixel_t       row_buf [SLOT_N][MAXW];
    int           row_pos, col_pos;
    logic [10:0]  width_reg, height_reg;
    logic [1:0]   radius_reg;
    logic [48:0]  mask_reg;
    logic         mode_reg;
    morph_pix_t   expected_pixels[$];

    int  errors = 0;
    int  quiet_cycles = 0;
    int  send_idle_pct = 0, recv_idle_pct = 0;
    int  phase_words;
    bit  hold_go = 0;

    function automatic int eff_w();
        return (width_reg == 0) ? 1 : (width_reg > MAXW) ? MAXW : int'(width_reg);
    endfunction

    function automatic int eff_h();
        return (height_reg == 0) ? 1 : int'(height_reg);
    endfunction

    function automatic morph_pix_t morph_pixel(int oi, int oj);
        morph_pix_t res;
        pixel_t     best, v;
        int         ni, nj, rad;
        rad  = radius_reg;
        best = row_buf[oi % SLOT_N][oj];
        for (int a = 0; a < 2 * rad + 1; a++) begin
            for (int b = 0; b < 2 * rad + 1; b++) begin
                ni = oi + a - rad;
                nj = oj + b - rad;
                if (mask_reg[a * MASK_STRIDE + b] && ni >= 0 && nj >= 0 &&
                    ni < eff_h() && nj < eff_w()) begin
                    v = row_buf[ni % SLOT_N][nj];
                    if (mode_reg == MODE_ERODE ? (v < best) : (v > best)) best = v;
                end
            end
        end
        res.red        = best[23:16];
        res.green      = best[15:8];
        res.blue       = best[7:0];
        res.last_run   = 1'b0;
        res.last_frame = (oi == eff_h() - 1 && oj == eff_w() - 1);
        return res;
    endfunction

    function automatic void wrap_pos();
        if (col_pos >= eff_w()) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= eff_h() + int'(radius_reg)) row_pos = 0;
    endfunction

    function automatic void predict_word(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int w, h, rad, oi, base;
        w = eff_w(); h = eff_h(); rad = radius_reg;
        base = expected_pixels.size();
        wrap_pos();
        row_buf[row_pos % SLOT_N][col_pos] = {r, g, b};
        if (row_pos >= rad && row_pos - rad < h) begin
            oi = row_pos - rad;
            if (col_pos < w - 1) begin
                if (col_pos >= rad) expected_pixels.push_back(morph_pixel(oi, col_pos - rad));
            end else begin
                for (int j = (col_pos >= rad ? col_pos - rad : 0); j < w; j++)
                    expected_pixels.push_back(morph_pixel(oi, j));
            end
        end
        if (expected_pixels.size() > base) expected_pixels[$].last_run = 1'b1;
        col_pos++;
        wrap_pos();
    endfunction

    // result checker
    always @(posedge aclk) begin
        morph_pix_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected result word");
                errors++;
            end else begin
                e = expected_pixels.pop_front();
                if (m_out_red !== e.red) begin
                    $error("out_red exp %0h got %0h", e.red, m_out_red); errors++;
                end
                if (m_out_green !== e.green) begin
                    $error("out_green exp %0h got %0h", e.green, m_out_green); errors++;
                end
                if (m_out_blue !== e.blue) begin
                    $error("out_blue exp %0h got %0h", e.blue, m_out_blue); errors++;
                end
                if (m_last_of_run !== e.last_run) begin
                    $error("last_of_run exp %0b got %0b", e.last_run, m_last_of_run);
                    errors++;
                end
                if (m_last_of_frame !== e.last_frame) begin
                    $error("last_of_frame exp %0b got %0b", e.last_frame, m_last_of_frame);
                    errors++;
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles = 0;
        end else if (++quiet_cycles >= WDOG_LIMIT) begin
            $display("lexicographic_color_morphology_core: mismatch");
            $finish;
        end
    end

    // result side ready, with an occasional long hold-off
    always begin
        @(negedge aclk);
        if (hold_go) begin
            m_ready = 1'b0;
            repeat (HOLD_LEN) @(negedge aclk);
            hold_go = 0;
        end
        m_ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_word(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_cmd   = cmd;
        s_red   = r;
        s_green = g;
        s_blue  = b;
        do @(posedge aclk); while (!s_ready);
        predict_word(r, g, b);
        phase_words++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_index   = idx;
        cfg_wr_data = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_FRAME_WIDTH:  width_reg  = data[10:0];
            CFG_FRAME_HEIGHT: height_reg = data[10:0];
            CFG_RADIUS:       radius_reg = data[1:0];
            CFG_WINDOW_MASK:  mask_reg   = data[48:0];
            CFG_MODE:         mode_reg   = data[0];
            default: ;
        endcase
    endtask

    task automatic set_all(int w, int h, int r, logic [48:0] mask, logic md);
        cfg_write(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
        cfg_write(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
        cfg_write(CFG_RADIUS, CFG_DATA_W'(r));
        cfg_write(CFG_WINDOW_MASK, CFG_DATA_W'(mask));
        cfg_write(CFG_MODE, CFG_DATA_W'(md));
    endtask

    // one full frame plus flush rows; a few words carry the "wrong" kind
    task automatic run_frame(int w, int h, int r, logic [48:0] mask, logic md, bit squeeze);
        int         n_rows;
        logic       cmd;
        logic [7:0] rd;
        set_all(w, h, r, mask, md);
        n_rows = eff_h() + int'(radius_reg);
        for (int i = 0; i < n_rows; i++) begin
            for (int j = 0; j < eff_w(); j++) begin
                if (squeeze && i == 0 && j == 0) hold_go = 1;
                cmd = (i < eff_h()) ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 9) != 0);
                // narrow red range forces ties, so green and blue decide
                rd  = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
                send_word(cmd, rd, 8'($urandom), 8'($urandom));
            end
        end
        drain();
    endtask

    task automatic random_frames(int goal);
        phase_words = 0;
        while (phase_words < goal)
            run_frame($urandom_range(1, 5), $urandom_range(1, 3), $urandom_range(0, 3),
                      MASK_W'({$urandom, $urandom}), 1'($urandom_range(0, 1)), 0);
    endtask

    stim_row_t spot_rows[12] = '{
        '{1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00},
        '{1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF},
        '{1'b1, 8'hAA, 8'h55, 8'h0F, 1'b1, 8'hAA, 8'h55, 8'h0F},
        '{1'b0, 8'h80, 8'h01, 8'hFE, 1'b1, 8'h80, 8'h01, 8'hFE},
        '{1'b1, 8'h01, 8'h80, 8'h7F, 1'b1, 8'h01, 8'h80, 8'h7F},
        '{1'b0, 8'hFF, 8'h00, 8'h00, 1'b1, 8'hFF, 8'h00, 8'h00},
        '{1'b0, 8'h00, 8'hFF, 8'h00, 1'b1, 8'h00, 8'hFF, 8'h00},
        '{1'b0, 8'h00, 8'h00, 8'hFF, 1'b1, 8'h00, 8'h00, 8'hFF},
        '{1'b1, 8'h55, 8'hAA, 8'hF0, 1'b1, 8'h55, 8'hAA, 8'hF0},
        '{1'b0, 8'h7F, 8'hFE, 8'h01, 1'b1, 8'h7F, 8'hFE, 8'h01},
        '{1'b0, 8'h12, 8'h34, 8'h56, 1'b0, 8'h00, 8'h00, 8'h00},
        '{1'b1, 8'hFF, 8'hFF, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00}
    };

    initial begin
        morph_pix_t tmp;
        row_pos = 0; col_pos = 0;
        width_reg = 11'd64; height_reg = 11'd64; radius_reg = 2'd1;
        mask_reg = 49'd115591; mode_reg = MODE_DILATE;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // zero width and height act as a 1x1 frame: each word comes straight back
        send_idle_pct = 19; recv_idle_pct = 76;
        set_all(0, 0, 0, '0, MODE_DILATE);
        foreach (spot_rows[k]) begin
            send_word(spot_rows[k].cmd, spot_rows[k].red, spot_rows[k].green,
                      spot_rows[k].blue);
            if (spot_rows[k].typed) begin
                tmp = expected_pixels[$];
                tmp.red   = spot_rows[k].e_red;
                tmp.green = spot_rows[k].e_green;
                tmp.blue  = spot_rows[k].e_blue;
                expected_pixels[$] = tmp;
            end
        end
        drain();

        run_frame(3, 3, 1, 49'd115591, MODE_DILATE, 0);
        run_frame(4, 3, 3, {49{1'b1}}, MODE_ERODE, 0);
        run_frame(0, 3, 1, '0, MODE_ERODE, 0);         // zero width acts as one column
        run_frame(4, 2, 2, '0, MODE_DILATE, 0);

        random_frames(8);
        send_idle_pct = 76; recv_idle_pct = 19;
        random_frames(8);
        send_idle_pct = 0; recv_idle_pct = 0;
        run_frame(4, 2, 1, {49{1'b1}}, MODE_DILATE, 1);
        random_frames(8);

        drain();
        if (errors == 0)
            $display("lexicographic_color_morphology_core: match");
        else
            $display("lexicographic_color_morphology_core: mismatch");
        $finish;
    end

endmodule
